/* rtl/clos_pkg.sv */
// clos_pkg: capacities, field widths, mode codes and memory record types
// for the loop order selector; no dependencies
`default_nettype none
package clos_pkg;

  localparam int MAX_LOOPS    = 64;
  localparam int MAX_VERTICES = 4096;
  localparam int LW = $clog2(MAX_LOOPS);
  localparam int VW = $clog2(MAX_VERTICES);

  // fixed field widths
  localparam int CW  = 24;
  localparam int GW  = 6;
  localparam int DPW = 6;
  localparam int PW  = 7;
  localparam int AW  = 32;
  // squared distance width, all ones means no vertex
  localparam int DW  = 2 * CW + 2;
  localparam logic [DW-1:0] DIST_INF = '1;

  // order modes, anything else is inner first
  localparam logic [1:0] MODE_AREA    = 2'd0;
  localparam logic [1:0] MODE_NEAREST = 2'd1;
  localparam logic [1:0] MODE_RESET   = 2'd2;

  // register word indexes
  localparam logic REG_ORDER_MODE = 1'b0;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } point_t;

  typedef struct packed {
    logic [VW-1:0]  first;
    logic [VW:0]    cnt;
    logic [GW-1:0]  grp;
    logic [DPW-1:0] dep;
    logic [PW-1:0]  par;
    logic [AW-1:0]  area;
    logic           hole;
    point_t         ep;
  } loop_rec_t;

  typedef struct packed {
    logic [DPW-1:0] dep;
    logic [AW-1:0]  area;
  } grp_rec_t;

  typedef struct packed {
    logic [AW-1:0] garea;
    logic          solid;
    logic [AW-1:0] area;
  } sort_key_t;

endpackage
`default_nettype wire

/* rtl/clos_ram.sv */
// clos_ram: generic single write port ram with one registered read port
// no dependencies
`default_nettype none
module clos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read first port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/cut_loop_order_selector.sv */
// cut_loop_order_selector: loads loops one item per cycle (in_ready high while loading).
// ordering walk after the last item: area mode builds group areas and sort keys, then scans all loops
// per pick; inner mode scans all loops per pick; nearest mode also reads every vertex of each candidate
// loop per pick (one vertex memory read per cycle); each result waits for the output register.
// synchronous active-low reset clears control state; memories hold no reset value.
// depends on clos_pkg and clos_ram
`default_nettype none
module cut_loop_order_selector (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [23:0] in_sample_x,
  input  logic signed [23:0] in_sample_y,
  input  logic        in_no_samples,
  input  logic [5:0]  in_region_group,
  input  logic [5:0]  in_nesting_depth,
  input  logic [6:0]  in_parent_loop,
  input  logic [31:0] in_loop_area,
  input  logic        in_hole_flag,
  input  logic        in_last_vertex,
  input  logic        in_last_loop,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_loop_index,
  output logic        out_final_result,
  output logic        out_overflow
);

  localparam int LW = clos_pkg::LW;
  localparam int VW = clos_pkg::VW;
  localparam int CW = clos_pkg::CW;
  localparam int DW = clos_pkg::DW;
  localparam int MAX_L = clos_pkg::MAX_LOOPS;

  typedef enum logic [14:0] {
    S_LOAD   = 15'b000000000000001,
    S_OVF    = 15'b000000000000010,
    S_G_RD   = 15'b000000000000100,
    S_G_GRD  = 15'b000000000001000,
    S_G_WR   = 15'b000000000010000,
    S_K_RD   = 15'b000000000100000,
    S_K_GRD  = 15'b000000001000000,
    S_K_WR   = 15'b000000010000000,
    S_A_RD   = 15'b000000100000000,
    S_A_EV   = 15'b000001000000000,
    S_P_RD   = 15'b000010000000000,
    S_P_EVAL = 15'b000100000000000,
    S_P_VTX  = 15'b001000000000000,
    S_P_CMP  = 15'b010000000000000,
    S_EMIT   = 15'b100000000000000
  } state_t;

  state_t state_r;

  // configuration register
  logic [1:0] mode_r;
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == clos_pkg::REG_ORDER_MODE) begin
      prdata = {30'd0, mode_r};
    end
  end

  // load state
  logic              loop_open_r, dropping_r, ovf_r;
  logic [LW:0]       lcnt_r;
  logic [VW:0]       vcnt_r;
  logic [VW-1:0]     cur_first_r;
  logic [VW:0]       cur_cnt_r;
  clos_pkg::point_t  cur_ep_r;

  // ordering state
  logic [LW:0]       idx_r, emit_r;
  logic              found_r, have_last_r;
  logic [MAX_L-1:0]  taken_r;
  logic [63:0]       gv_r;
  clos_pkg::point_t  cur_r;

  // best and candidate loop
  logic [LW-1:0]                 b_idx_r, c_idx_r, l_idx_r;
  logic [clos_pkg::DPW-1:0]      b_dep_r, c_dep_r;
  logic [clos_pkg::AW-1:0]       b_area_r, c_area_r;
  logic                          b_adj_r, c_adj_r;
  logic [DW-1:0]                 b_d_r, dmin_r;
  clos_pkg::point_t              b_ep_r, c_ep_r;
  logic [clos_pkg::GW-1:0]       b_grp_r, c_grp_r, l_grp_r;
  logic [clos_pkg::PW-1:0]       b_par_r, c_par_r, l_par_r;
  clos_pkg::sort_key_t           b_key_r;
  logic [VW-1:0]                 c_first_r;
  logic [VW:0]                   c_cnt_r, k_r;

  // group pass scratch
  logic [clos_pkg::GW-1:0]       g_grp_r;
  logic [clos_pkg::DPW-1:0]      g_dep_r;
  logic [clos_pkg::AW-1:0]       g_area_r;
  logic                          g_hole_r;

  // distance pipeline
  logic                          p1_r, p2_r, p3_r;
  logic signed [CW:0]            dx_r, dy_r;
  logic [2*CW-1:0]               sqx_r, sqy_r;
  logic signed [2*CW+1:0]        mx, my;
  logic [2*CW:0]                 dsum;

  // output register
  logic       out_valid_r, out_final_r, out_ovf_r;
  logic [5:0] out_idx_r;

  // memory ports
  clos_pkg::loop_rec_t  lrd, lwd;
  clos_pkg::grp_rec_t   grd, gwd;
  clos_pkg::sort_key_t  krd, kwd;
  clos_pkg::point_t     vrd, vwd;
  logic                 lwe, gwe, kwe, vwe;
  logic [LW-1:0]        lwa;
  logic [VW-1:0]        vwa, vra;

  clos_ram #(.WIDTH($bits(clos_pkg::point_t)), .DEPTH(clos_pkg::MAX_VERTICES)) u_vmem (
    .clk(clk), .we(vwe), .waddr(vwa), .wdata(vwd), .raddr(vra), .rdata(vrd));
  clos_ram #(.WIDTH($bits(clos_pkg::loop_rec_t)), .DEPTH(MAX_L)) u_lmem (
    .clk(clk), .we(lwe), .waddr(lwa), .wdata(lwd), .raddr(idx_r[LW-1:0]), .rdata(lrd));
  clos_ram #(.WIDTH($bits(clos_pkg::grp_rec_t)), .DEPTH(1 << clos_pkg::GW)) u_gmem (
    .clk(clk), .we(gwe), .waddr(g_grp_r), .wdata(gwd), .raddr(lrd.grp), .rdata(grd));
  clos_ram #(.WIDTH($bits(clos_pkg::sort_key_t)), .DEPTH(MAX_L)) u_kmem (
    .clk(clk), .we(kwe), .waddr(idx_r[LW-1:0]), .wdata(kwd), .raddr(idx_r[LW-1:0]),
    .rdata(krd));

  // handshake
  logic in_acc, slot_free, cfg_wr;
  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign out_valid        = out_valid_r;
  assign out_loop_index   = out_idx_r;
  assign out_final_result = out_final_r;
  assign out_overflow     = out_ovf_r;

  // item load decode
  logic           open_now, drop, vfull, store_v, ovf_add, set_ep, closing;
  logic [VW:0]    cnt0, cnt1;
  logic [LW:0]    n_new;
  clos_pkg::point_t in_pt, ep;

  always_comb begin
    in_pt    = '{x: in_sample_x, y: in_sample_y};
    open_now = !loop_open_r;
    drop     = open_now ? (lcnt_r >= (LW+1)'(MAX_L)) : dropping_r;
    cnt0     = open_now ? '0 : cur_cnt_r;
    vfull    = vcnt_r >= (VW+1)'(clos_pkg::MAX_VERTICES);
    store_v  = !drop && !in_no_samples && !vfull;
    ovf_add  = (open_now && drop) || (!drop && !in_no_samples && vfull);
    cnt1     = cnt0 + (VW+1)'(store_v);
    set_ep   = store_v || (!drop && in_no_samples && (cnt0 == '0));
    ep       = set_ep ? in_pt : cur_ep_r;
    closing  = in_last_vertex || in_last_loop;
    n_new    = (closing && !drop) ? lcnt_r + (LW+1)'(1) : lcnt_r;
  end

  // memory writes
  logic g_upd;
  always_comb begin
    lwe = in_acc && !drop;
    lwa = lcnt_r[LW-1:0];
    lwd = '{first: (open_now ? vcnt_r[VW-1:0] : cur_first_r), cnt: cnt1,
            grp: in_region_group, dep: in_nesting_depth, par: in_parent_loop,
            area: in_loop_area, hole: in_hole_flag, ep: ep};
    vwe = in_acc && store_v;
    vwa = vcnt_r[VW-1:0];
    vwd = in_pt;
    g_upd = !gv_r[g_grp_r] || (g_dep_r <= grd.dep);
    gwe = (state_r == S_G_WR) && g_upd;
    gwd = '{dep: g_dep_r, area: g_area_r};
    kwe = (state_r == S_K_WR);
    kwd = '{garea: grd.area, solid: !g_hole_r, area: g_area_r};
    vra = c_first_r + k_r[VW-1:0];
  end

  // scan and pick decisions
  logic [LW:0] idx_inc;
  logic        idx_end, issue, vtx_done, cand, cadj, take, better, final_pick;
  always_comb begin
    idx_inc  = idx_r + (LW+1)'(1);
    idx_end  = (idx_inc == lcnt_r);
    issue    = (k_r < c_cnt_r);
    vtx_done = !issue && !p1_r && !p2_r && !p3_r;
    cand     = !taken_r[idx_r[LW-1:0]] && (!found_r || (lrd.dep >= b_dep_r));
    cadj     = have_last_r && ((lrd.grp == l_grp_r) ||
               (lrd.par == clos_pkg::PW'(l_idx_r)) || (lrd.par == l_par_r));
    if (mode_r == clos_pkg::MODE_NEAREST) begin
      better = dmin_r < b_d_r;
    end else if (c_adj_r != b_adj_r) begin
      better = c_adj_r;
    end else begin
      better = c_area_r < b_area_r;
    end
    take = !found_r || (c_dep_r > b_dep_r) || ((c_dep_r == b_dep_r) && better);
    final_pick = ((emit_r + (LW+1)'(1)) == lcnt_r);
    mx   = dx_r * dx_r;
    my   = dy_r * dy_r;
    dsum = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      mode_r      <= clos_pkg::MODE_RESET;
      loop_open_r <= 1'b0;
      dropping_r  <= 1'b0;
      ovf_r       <= 1'b0;
      lcnt_r      <= '0;
      vcnt_r      <= '0;
      taken_r     <= '0;
      gv_r        <= '0;
      idx_r       <= '0;
      emit_r      <= '0;
      found_r     <= 1'b0;
      have_last_r <= 1'b0;
      cur_r       <= '0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      p3_r        <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == clos_pkg::REG_ORDER_MODE)) begin
        mode_r <= pwdata[1:0];
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // distance pipeline
      p1_r <= (state_r == S_P_VTX) && issue;
      p2_r <= p1_r;
      p3_r <= p2_r;
      if (p1_r) begin
        dx_r <= (CW+1)'(vrd.x) - (CW+1)'(cur_r.x);
        dy_r <= (CW+1)'(vrd.y) - (CW+1)'(cur_r.y);
      end
      if (p2_r) begin
        sqx_r <= mx[2*CW-1:0];
        sqy_r <= my[2*CW-1:0];
      end
      if (p3_r && (DW'(dsum) < dmin_r)) begin
        dmin_r <= DW'(dsum);
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            loop_open_r <= !closing;
            dropping_r  <= closing ? 1'b0 : drop;
            cur_first_r <= lwd.first;
            cur_cnt_r   <= cnt1;
            cur_ep_r    <= ep;
            vcnt_r      <= vcnt_r + (VW+1)'(store_v);
            lcnt_r      <= n_new;
            ovf_r       <= ovf_r || ovf_add;
            if (in_last_loop) begin
              ovf_r       <= 1'b0;
              vcnt_r      <= '0;
              idx_r       <= '0;
              emit_r      <= '0;
              found_r     <= 1'b0;
              have_last_r <= 1'b0;
              cur_r       <= '0;
              gv_r        <= '0;
              if (ovf_r || ovf_add) begin
                state_r <= S_OVF;
              end else if (n_new == '0) begin
                lcnt_r <= '0;
              end else if (mode_r == clos_pkg::MODE_AREA) begin
                state_r <= S_G_RD;
              end else begin
                state_r <= S_P_RD;
              end
            end
          end
        end
        S_OVF: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= '0;
            out_final_r <= 1'b1;
            out_ovf_r   <= 1'b1;
            lcnt_r      <= '0;
            state_r     <= S_LOAD;
          end
        end
        // group area: shallowest loop of each group, last one wins
        S_G_RD: state_r <= S_G_GRD;
        S_G_GRD: begin
          g_grp_r  <= lrd.grp;
          g_dep_r  <= lrd.dep;
          g_area_r <= lrd.area;
          state_r  <= S_G_WR;
        end
        S_G_WR: begin
          if (g_upd) begin
            gv_r[g_grp_r] <= 1'b1;
          end
          if (idx_end) begin
            idx_r   <= '0;
            state_r <= S_K_RD;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_G_RD;
          end
        end
        // sort key per loop
        S_K_RD: state_r <= S_K_GRD;
        S_K_GRD: begin
          g_grp_r  <= lrd.grp;
          g_hole_r <= lrd.hole;
          g_area_r <= lrd.area;
          state_r  <= S_K_WR;
        end
        S_K_WR: begin
          if (idx_end) begin
            idx_r   <= '0;
            state_r <= S_A_RD;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_K_RD;
          end
        end
        // area mode: smallest key, earliest loop on ties
        S_A_RD: state_r <= S_A_EV;
        S_A_EV: begin
          if (!taken_r[idx_r[LW-1:0]] && (!found_r || (krd < b_key_r))) begin
            found_r <= 1'b1;
            b_key_r <= krd;
            b_idx_r <= idx_r[LW-1:0];
          end
          if (idx_end) begin
            state_r <= S_EMIT;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_A_RD;
          end
        end
        // depth modes: deepest untaken loops compete
        S_P_RD: state_r <= S_P_EVAL;
        S_P_EVAL: begin
          c_idx_r   <= idx_r[LW-1:0];
          c_dep_r   <= lrd.dep;
          c_area_r  <= lrd.area;
          c_adj_r   <= cadj;
          c_ep_r    <= lrd.ep;
          c_grp_r   <= lrd.grp;
          c_par_r   <= lrd.par;
          c_first_r <= lrd.first;
          c_cnt_r   <= lrd.cnt;
          k_r       <= '0;
          dmin_r    <= clos_pkg::DIST_INF;
          if (!cand) begin
            if (idx_end) begin
              state_r <= S_EMIT;
            end else begin
              idx_r   <= idx_inc;
              state_r <= S_P_RD;
            end
          end else if (mode_r == clos_pkg::MODE_NEAREST) begin
            state_r <= S_P_VTX;
          end else begin
            state_r <= S_P_CMP;
          end
        end
        S_P_VTX: begin
          k_r <= k_r + (VW+1)'(issue);
          if (vtx_done) begin
            state_r <= S_P_CMP;
          end
        end
        S_P_CMP: begin
          if (take) begin
            found_r  <= 1'b1;
            b_idx_r  <= c_idx_r;
            b_dep_r  <= c_dep_r;
            b_area_r <= c_area_r;
            b_adj_r  <= c_adj_r;
            b_d_r    <= dmin_r;
            b_ep_r   <= c_ep_r;
            b_grp_r  <= c_grp_r;
            b_par_r  <= c_par_r;
          end
          if (idx_end) begin
            state_r <= S_EMIT;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_P_RD;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r      <= 1'b1;
            out_idx_r        <= 6'(b_idx_r);
            out_final_r      <= final_pick;
            out_ovf_r        <= 1'b0;
            taken_r[b_idx_r] <= 1'b1;
            have_last_r      <= 1'b1;
            l_idx_r          <= b_idx_r;
            l_grp_r          <= b_grp_r;
            l_par_r          <= b_par_r;
            cur_r            <= b_ep_r;
            emit_r           <= emit_r + (LW+1)'(1);
            idx_r            <= '0;
            found_r          <= 1'b0;
            if (final_pick) begin
              lcnt_r  <= '0;
              taken_r <= '0;
              cur_r   <= '0;
              state_r <= S_LOAD;
            end else if (mode_r == clos_pkg::MODE_AREA) begin
              state_r <= S_A_RD;
            end else begin
              state_r <= S_P_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // checks
  a_taken_clear_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (taken_r == '0))
    else $error("taken flags set while loading");
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (emit_r < lcnt_r))
    else $error("more picks than loops");
  a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P_CMP) |-> !(p1_r || p2_r || p3_r))
    else $error("distance pipeline busy at compare");
  a_ovf_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> out_final_r)
    else $error("overflow item not final");

endmodule
`default_nettype wire
